// ----- design/actuator_command_safety_supervisor_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the actuator command safety supervisor
// Concurrent assertion shorthands clocked on a rising edge, reset low.
// ----------------------------------------------------------------------------
`ifndef ACTUATOR_COMMAND_SAFETY_SUPERVISOR_MACROS_SVH
`define ACTUATOR_COMMAND_SAFETY_SUPERVISOR_MACROS_SVH

// Check an expression at every clock edge outside reset
`define ACSS_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a consequent in the same cycle as its antecedent
`define ACSS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define ACSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/acss_pkg.sv -----
// ----------------------------------------------------------------------------
// acss_pkg
// Shared types and constants of the actuator command safety supervisor.
// ----------------------------------------------------------------------------
package acss_pkg;

    // Widths
    localparam int DEF_AGE_WIDTH = 17;
    localparam int HOLD_WIDTH    = 16;
    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 2;

    // Register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_WATCHDOG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_LONG_PRESS       = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_WATCHDOG_ENABLE  = 2'd2;

    // Register reset values
    localparam logic [CFG_WIDTH-1:0] RST_WATCHDOG_TIMEOUT = 16'd500;
    localparam logic [CFG_WIDTH-1:0] RST_LONG_PRESS       = 16'd3000;

    // Status codes
    localparam logic [1:0] STATUS_DISCONNECTED = 2'd0;
    localparam logic [1:0] STATUS_CONNECTED    = 2'd1;
    localparam logic [1:0] STATUS_READY        = 2'd2;

    localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = '1;

    // One tick as received
    typedef struct packed {
        logic button_down;
        logic base_cmd_seen;
        logic base_cmd_full;
        logic arm_cmd_seen;
        logic arm_cmd_full;
    } tick_t;

    // Single-bit supervisor state
    typedef struct packed {
        logic button_held;
        logic long_press_done;
        logic drive_on;
        logic connected;
        logic base_halt;
        logic arm_halt;
    } flags_t;

    // One result
    typedef struct packed {
        logic [1:0] system_status;
        logic       drive_enabled;
        logic       link_up;
        logic       base_brake_pulse;
        logic       arm_torque_off_pulse;
        logic       arm_torque_on_pulse;
        logic       base_forward;
        logic       arm_forward;
        logic       base_stopped;
        logic       arm_stopped;
    } result_t;

endpackage

// ----- design/acss_step.sv -----
// ----------------------------------------------------------------------------
// acss_step
// Next-state and result logic for one tick: ages, long press, commands,
// watchdog stops and link loss.
// ----------------------------------------------------------------------------
module acss_step #(
    parameter int AGE_WIDTH = acss_pkg::DEF_AGE_WIDTH
) (
    input  acss_pkg::tick_t                 tick,
    input  acss_pkg::flags_t                flags,
    input  logic [AGE_WIDTH-1:0]            base_age,
    input  logic [AGE_WIDTH-1:0]            arm_age,
    input  logic [acss_pkg::HOLD_WIDTH-1:0] hold_count,
    input  logic [acss_pkg::CFG_WIDTH-1:0]  cmd_timeout_ms,
    input  logic [acss_pkg::CFG_WIDTH-1:0]  long_press_ms,
    input  logic                            watchdog_enable,
    output acss_pkg::flags_t                flags_next,
    output logic [AGE_WIDTH-1:0]            base_age_next,
    output logic [AGE_WIDTH-1:0]            arm_age_next,
    output logic [acss_pkg::HOLD_WIDTH-1:0] hold_count_next,
    output acss_pkg::result_t               result
);

    localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;

    logic [AGE_WIDTH-1:0]            base_inc;
    logic [AGE_WIDTH-1:0]            arm_inc;
    logic [AGE_WIDTH-1:0]            limit;
    logic [AGE_WIDTH-1:0]            limit2;
    logic [acss_pkg::HOLD_WIDTH-1:0] hold_inc;

    // Saturating increments and timeout limits
    assign base_inc = (base_age == AGE_MAX) ? base_age : base_age + AGE_WIDTH'(1);
    assign arm_inc  = (arm_age == AGE_MAX) ? arm_age : arm_age + AGE_WIDTH'(1);
    assign hold_inc = (hold_count == acss_pkg::HOLD_MAX) ? hold_count
                                                         : hold_count + 16'd1;
    assign limit    = AGE_WIDTH'(cmd_timeout_ms);
    assign limit2   = AGE_WIDTH'({cmd_timeout_ms, 1'b0});

    // Advance the state in tick order
    always_comb
    begin
        acss_pkg::flags_t f;
        logic brake;
        logic toff;
        logic ton;
        logic bfwd;
        logic afwd;
        logic [AGE_WIDTH-1:0] ba;
        logic [AGE_WIDTH-1:0] aa;
        logic [acss_pkg::HOLD_WIDTH-1:0] hc;

        f     = flags;
        brake = 1'b0;
        toff  = 1'b0;
        ton   = 1'b0;
        bfwd  = 1'b0;
        afwd  = 1'b0;
        ba    = base_inc;
        aa    = arm_inc;
        hc    = hold_count;

        // Button: press tracking and long-press toggle
        if (tick.button_down && !f.button_held)
        begin
            hc                = '0;
            f.button_held     = 1'b1;
            f.long_press_done = 1'b0;
        end
        else if (tick.button_down && !f.long_press_done)
        begin
            hc = hold_inc;
            if (hold_inc >= long_press_ms)
            begin
                f.long_press_done = 1'b1;
                f.drive_on        = !f.drive_on;
                if (!flags.drive_on)
                begin
                    ton = 1'b1;
                end
                else
                begin
                    brake = 1'b1;
                    toff  = 1'b1;
                end
            end
        end
        else if (!tick.button_down && f.button_held)
        begin
            f.button_held     = 1'b0;
            f.long_press_done = 1'b0;
        end

        // Base command: refresh and release the stop
        if (tick.base_cmd_seen)
        begin
            ba          = '0;
            f.base_halt = 1'b0;
            f.connected = 1'b1;
            bfwd        = tick.base_cmd_full && f.drive_on;
        end

        // Arm command: refresh and recover with torque on
        if (tick.arm_cmd_seen)
        begin
            aa          = '0;
            f.connected = 1'b1;
            if (f.arm_halt)
            begin
                ton        = 1'b1;
                f.arm_halt = 1'b0;
            end
            afwd = tick.arm_cmd_full && f.drive_on;
        end

        // Watchdog: latch stops on timeout
        if (watchdog_enable)
        begin
            if (ba > limit && !f.base_halt)
            begin
                f.base_halt = 1'b1;
                brake       = 1'b1;
            end
            if (aa > limit && !f.arm_halt)
            begin
                f.arm_halt = 1'b1;
                toff       = 1'b1;
            end
        end

        // Link: drop when both channels are silent for twice the timeout
        if (f.connected && ba > limit2 && aa > limit2)
        begin
            f.connected = 1'b0;
        end

        flags_next      = f;
        base_age_next   = ba;
        arm_age_next    = aa;
        hold_count_next = hc;

        if (!f.connected)
        begin
            result.system_status = acss_pkg::STATUS_DISCONNECTED;
        end
        else if (!f.drive_on)
        begin
            result.system_status = acss_pkg::STATUS_CONNECTED;
        end
        else
        begin
            result.system_status = acss_pkg::STATUS_READY;
        end
        result.drive_enabled        = f.drive_on;
        result.link_up              = f.connected;
        result.base_brake_pulse     = brake;
        result.arm_torque_off_pulse = toff;
        result.arm_torque_on_pulse  = ton;
        result.base_forward         = bfwd;
        result.arm_forward          = afwd;
        result.base_stopped         = f.base_halt;
        result.arm_stopped          = f.arm_halt;
    end

endmodule

// ----- design/actuator_command_safety_supervisor.sv -----
// ----------------------------------------------------------------------------
// Actuator command safety supervisor
// Takes one request per millisecond tick on the input channel (button level
// and base/arm command flags) and returns one result request per tick with
// status, drive enable, link state, brake/torque pulses, forward flags and
// latched stops. Both channels use valid/stall; a request moves on an edge
// with valid high and stall low.
// An accepted request passes the input register, the state update and the
// result register. Throughput: one request per cycle while not stalled.
// When the receiver stalls, the result register holds; one more request
// may sit in the input register, after which in_stall rises.
// Registers are written on the cfg channel (cfg_ready is always high); the
// user must write them only while no request is in flight (not enforced).
// Reset clears the valid flags and supervisor state and restores the
// register defaults: timeout 500 ms, long press 3000 ms, watchdog off.
// ----------------------------------------------------------------------------
module actuator_command_safety_supervisor #(
    parameter int AGE_WIDTH = acss_pkg::DEF_AGE_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               button_down,
    input  logic                               base_cmd_seen,
    input  logic                               base_cmd_full,
    input  logic                               arm_cmd_seen,
    input  logic                               arm_cmd_full,
    // Result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         system_status,
    output logic                               drive_enabled,
    output logic                               link_up,
    output logic                               base_brake_pulse,
    output logic                               arm_torque_off_pulse,
    output logic                               arm_torque_on_pulse,
    output logic                               base_forward,
    output logic                               arm_forward,
    output logic                               base_stopped,
    output logic                               arm_stopped,
    // Configuration channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [acss_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [acss_pkg::CFG_WIDTH-1:0]     cfg_data
);

    logic                            in_valid_reg;
    acss_pkg::tick_t                 tick_reg;
    logic                            out_valid_reg;
    acss_pkg::result_t               result_reg;
    acss_pkg::result_t               result_next;

    acss_pkg::flags_t                flags_reg;
    acss_pkg::flags_t                flags_next;
    logic [AGE_WIDTH-1:0]            base_age_reg;
    logic [AGE_WIDTH-1:0]            base_age_next;
    logic [AGE_WIDTH-1:0]            arm_age_reg;
    logic [AGE_WIDTH-1:0]            arm_age_next;
    logic [acss_pkg::HOLD_WIDTH-1:0] hold_count_reg;
    logic [acss_pkg::HOLD_WIDTH-1:0] hold_count_next;

    logic [acss_pkg::CFG_WIDTH-1:0]  timeout_reg;
    logic [acss_pkg::CFG_WIDTH-1:0]  long_press_reg;
    logic                            wd_enable_reg;

    logic                            out_load;
    logic                            step;
    logic                            cfg_write;
    logic                            age_clear;

    // Pipeline handshake
    assign out_load  = !out_valid_reg || !out_stall;
    assign step      = in_valid_reg && out_load;
    assign in_stall  = in_valid_reg && !out_load;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign age_clear = cfg_write && (cfg_index == acss_pkg::CFG_WATCHDOG_ENABLE)
                       && cfg_data[0] && !wd_enable_reg;

    // Hold the accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            tick_reg <= '{button_down:    button_down,
                          base_cmd_seen:  base_cmd_seen,
                          base_cmd_full:  base_cmd_full,
                          arm_cmd_seen:   arm_cmd_seen,
                          arm_cmd_full:   arm_cmd_full};
        end
    end

    // Update logic for one tick
    acss_step #(
        .AGE_WIDTH (AGE_WIDTH)
    ) u_step (
        .tick            (tick_reg),
        .flags           (flags_reg),
        .base_age        (base_age_reg),
        .arm_age         (arm_age_reg),
        .hold_count      (hold_count_reg),
        .cmd_timeout_ms  (timeout_reg),
        .long_press_ms   (long_press_reg),
        .watchdog_enable (wd_enable_reg),
        .flags_next      (flags_next),
        .base_age_next   (base_age_next),
        .arm_age_next    (arm_age_next),
        .hold_count_next (hold_count_next),
        .result          (result_next)
    );

    // Advance the supervisor state; clear ages when the watchdog turns on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg      <= '0;
            base_age_reg   <= '0;
            arm_age_reg    <= '0;
            hold_count_reg <= '0;
        end
        else if (age_clear)
        begin
            base_age_reg <= '0;
            arm_age_reg  <= '0;
        end
        else if (step)
        begin
            flags_reg      <= flags_next;
            base_age_reg   <= base_age_next;
            arm_age_reg    <= arm_age_next;
            hold_count_reg <= hold_count_next;
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= acss_pkg::RST_WATCHDOG_TIMEOUT;
            long_press_reg <= acss_pkg::RST_LONG_PRESS;
            wd_enable_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                acss_pkg::CFG_WATCHDOG_TIMEOUT: timeout_reg    <= cfg_data;
                acss_pkg::CFG_LONG_PRESS:       long_press_reg <= cfg_data;
                acss_pkg::CFG_WATCHDOG_ENABLE:  wd_enable_reg  <= cfg_data[0];
                default:                        ;
            endcase
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    // Drive the result ports
    assign out_valid            = out_valid_reg;
    assign system_status        = result_reg.system_status;
    assign drive_enabled        = result_reg.drive_enabled;
    assign link_up              = result_reg.link_up;
    assign base_brake_pulse     = result_reg.base_brake_pulse;
    assign arm_torque_off_pulse = result_reg.arm_torque_off_pulse;
    assign arm_torque_on_pulse  = result_reg.arm_torque_on_pulse;
    assign base_forward         = result_reg.base_forward;
    assign arm_forward          = result_reg.arm_forward;
    assign base_stopped         = result_reg.base_stopped;
    assign arm_stopped          = result_reg.arm_stopped;

endmodule

// ----- design/acss_checker.sv -----
// ----------------------------------------------------------------------------
// acss_checker
// Port-level checks of the actuator command safety supervisor, bound to
// the top level.
// ----------------------------------------------------------------------------
`include "actuator_command_safety_supervisor_macros.svh"

module acss_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] system_status,
    input logic       drive_enabled,
    input logic       link_up,
    input logic       base_brake_pulse,
    input logic       arm_torque_off_pulse,
    input logic       arm_torque_on_pulse,
    input logic       base_forward,
    input logic       arm_forward,
    input logic       base_stopped,
    input logic       arm_stopped
);

    logic        status_ok;
    logic        base_fwd_seen;
    logic        base_fwd_ok;
    logic        arm_fwd_seen;
    logic        arm_fwd_ok;
    logic        out_held;
    logic [11:0] held_bits;

    // Status must agree with the link and drive flags
    assign status_ok =
        ((system_status == acss_pkg::STATUS_DISCONNECTED) == !link_up)
        && ((system_status == acss_pkg::STATUS_READY) == (link_up && drive_enabled))
        && ((system_status == acss_pkg::STATUS_CONNECTED) == (link_up && !drive_enabled));

    // A forwarded command needs drive on and no stop or stop pulse
    assign base_fwd_seen = out_valid && base_forward;
    assign base_fwd_ok   = drive_enabled && !base_stopped && !base_brake_pulse;
    assign arm_fwd_seen  = out_valid && arm_forward;
    assign arm_fwd_ok    = drive_enabled && !arm_stopped && !arm_torque_off_pulse;

    // A stalled result keeps valid and every field
    assign out_held  = out_valid && out_stall;
    assign held_bits = {out_valid, system_status, drive_enabled, link_up,
                        base_brake_pulse, arm_torque_off_pulse, arm_torque_on_pulse,
                        base_forward, arm_forward, base_stopped, arm_stopped};

    `ACSS_ASSERT_IMPLY(a_status_flags, clk, rst_n, out_valid, status_ok, "bad status code")

    `ACSS_ASSERT_IMPLY(a_base_fwd, clk, rst_n, base_fwd_seen, base_fwd_ok, "bad base forward")

    `ACSS_ASSERT_IMPLY(a_arm_fwd, clk, rst_n, arm_fwd_seen, arm_fwd_ok, "bad arm forward")

    `ACSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, $stable(held_bits), "stalled result moved")

endmodule

bind actuator_command_safety_supervisor acss_checker u_acss_checker (.*);
